// ----- hdl/hash_chain_table_assert.svh -----
// Assertion macros for the hash chain table.
`ifndef HASH_CHAIN_TABLE_ASSERT_SVH
`define HASH_CHAIN_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HCT_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("hash_chain_table check failed");
`define HCT_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("hash_chain_table check failed");
`else
`define HCT_ASSERT_IMPL(label, clk, rst_n, a, c)
`define HCT_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- hdl/hct_pkg.sv -----
// Types and constants shared by the hash chain table modules.
package hct_pkg;
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_FIND   = 2'd2;
	localparam logic [1:0] CMD_CHECK  = 2'd3;

	localparam logic [1:0] KIND_FIND  = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;
	localparam logic [1:0] KIND_FULL  = 2'd3;

	localparam logic [29:0] HASH_MUL = 30'd263;
	localparam logic [29:0] HASH_MOD = 30'd1000000007;
	localparam int MAX_RESULTS = 8;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] key_bytes;
		logic [3:0]  key_length;
		logic [5:0]  bucket_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        found;
		logic [63:0] entry_key;
		logic [3:0]  entry_length;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HASH, ST_MOD, ST_CNT, ST_SRCH, ST_DECIDE,
		ST_SHIFT, ST_LIST, ST_OUT, ST_CLEAR
	} state_t;
endpackage

// ----- hdl/hct_stream_if.sv -----
// Valid/ready channel carrying one payload type.
interface hct_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/hash_chain_table.sv -----
// Hash chain table: a keyed set stored as bucket chains in synchronous memories.
// Input channel "req" carries a command (add, delete, find, check) with a key of
// up to eight bytes. Output channel "rsp" returns results; last marks the final
// result of one command. Add and delete of no effect return nothing; find
// returns one result; check returns up to eight entries newest first or one
// empty-chain result; an add to a full chain returns one dropped result.
// One command is handled at a time. A keyed command hashes the key, reduces the
// hash to a bucket, reads the chain count, searches the chain slot by slot,
// decides and finishes; a delete that hits then shifts the later slots down.
// A check reads the count and lists the entries, or reports an empty chain.
// The rate is set by the slot memory and the serial hash unit.
// After reset the block clears the chain-count memory, one bucket per cycle,
// before it takes a command; configuration writes are taken.
// When the receiver stalls, the held result waits in the output register and
// no new command is taken until the result is delivered.
module hash_chain_table #(
	parameter int BUCKETS = 64,
	parameter int WAYS = 8,
	parameter int KEY_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	hct_stream_if.sink   req,
	hct_stream_if.source rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hct_pkg::*;
	`include "hash_chain_table_assert.svh"

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CW = $clog2(WAYS + 1);
	localparam int AW = BW + WW;

	logic [6:0] buckets_q;
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {25'd0, buckets_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) buckets_q <= 7'd64;
		else if (psel && penable && pwrite && paddr == 2'd0) buckets_q <= pwdata[6:0];
	end

	// Memories.
	logic [67:0]   slot_mem [BUCKETS*(2**WW)];
	logic [CW-1:0] cnt_mem [BUCKETS];
	logic [AW-1:0] s_raddr;
	logic [67:0]   s_rdata;
	logic          s_we;
	logic [AW-1:0] s_waddr;
	logic [67:0]   s_wdata;
	logic [BW-1:0] c_addr;
	logic [CW-1:0] c_rdata;
	logic          c_we;
	logic [CW-1:0] c_wdata;
	always_ff @(posedge clk) begin
		if (s_we) slot_mem[s_waddr] <= s_wdata;
		s_rdata <= slot_mem[s_raddr];
	end
	always_ff @(posedge clk) begin
		if (c_we) cnt_mem[c_addr] <= c_wdata;
		c_rdata <= cnt_mem[c_addr];
	end

	state_t state_q, state_d;
	req_t   cmd_q;
	logic [63:0] key_q;
	logic [3:0]  len_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] cnt_q, i_q;
	logic          hit_q, rd_pend_q, oor_q;
	logic [BW:0]   clr_q;
	rsp_t          out_q;
	logic          out_v_q;

	logic hash_start, hash_done;
	logic [11:0] hash_bucket;
	logic [3:0]  len_sat;
	logic [63:0] key_mask;

	assign len_sat = (req.data.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req.data.key_length;
	always_comb begin
		for (int k = 0; k < 8; k++)
			key_mask[8*k +: 8] = (4'(k) < len_sat) ? req.data.key_bytes[8*k +: 8] : 8'd0;
	end

	logic [6:0] nb_eff;
	assign nb_eff = (32'(buckets_q) > BUCKETS) ? 7'(BUCKETS) : buckets_q;

	hct_hash u_hash (
		.clk(clk), .arst_n(arst_n), .start(hash_start), .key(key_q), .len(len_q),
		.buckets(nb_eff), .done(hash_done), .bucket(hash_bucket)
	);

	assign req.ready = (state_q == ST_IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;

	logic accept;
	assign accept = req.valid && req.ready;
	logic key_match;
	assign key_match = (s_rdata[63:0] == key_q) && (s_rdata[67:64] == len_q);
	logic out_free;
	assign out_free = !out_v_q || rsp.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == (BW+1)'(BUCKETS - 1)) state_d = ST_IDLE;
			ST_IDLE: if (accept) state_d = (req.data.command == CMD_CHECK) ? ST_CNT : ST_HASH;
			ST_HASH: state_d = ST_MOD;
			ST_MOD: if (hash_done) state_d = ST_CNT;
			ST_CNT: if (rd_pend_q) state_d = (cmd_q.command == CMD_CHECK) ? ST_LIST : ST_SRCH;
			ST_SRCH: if (rd_pend_q && (key_match || i_q == cnt_q)) state_d = ST_DECIDE;
				else if (!rd_pend_q && i_q == cnt_q) state_d = ST_DECIDE;
			ST_DECIDE: state_d = (cmd_q.command == CMD_DELETE && hit_q) ? ST_SHIFT : ST_OUT;
			ST_SHIFT: if (i_q + CW'(1) >= cnt_q && !rd_pend_q) state_d = ST_IDLE;
			ST_LIST: if (i_q == '0 && out_free && !rd_pend_q) state_d = ST_IDLE;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs to memories and hash.
	always_comb begin
		hash_start = (state_q == ST_HASH);
		s_raddr = {b_q, WW'(i_q)};
		s_we = 1'b0;
		s_waddr = {b_q, WW'(i_q)};
		s_wdata = s_rdata;
		c_addr = b_q;
		c_we = 1'b0;
		c_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				c_addr = BW'(clr_q);
				c_we = 1'b1;
			end
			ST_DECIDE: begin
				if (cmd_q.command == CMD_ADD && !hit_q && cnt_q < CW'(WAYS)) begin
					s_we = 1'b1;
					s_waddr = {b_q, WW'(cnt_q)};
					s_wdata = {len_q, key_q};
					c_we = 1'b1;
					c_wdata = cnt_q + CW'(1);
				end
				if (cmd_q.command == CMD_DELETE && hit_q) begin
					c_we = 1'b1;
					c_wdata = cnt_q - CW'(1);
				end
				s_raddr = {b_q, WW'(i_q + CW'(1))};
			end
			ST_SHIFT: begin
				s_raddr = {b_q, WW'(i_q + CW'(1))};
				s_we = rd_pend_q;
				s_waddr = {b_q, WW'(i_q)};
			end
			ST_LIST: s_raddr = {b_q, WW'(i_q - CW'(1))};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_v_q <= 1'b0;
			rd_pend_q <= 1'b0;
			hit_q <= 1'b0;
			i_q <= '0;
		end else begin
			state_q <= state_d;
			// A listed entry that refills the output register keeps it valid.
			if (out_v_q && rsp.ready && !(state_q == ST_LIST && rd_pend_q)) out_v_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: if (accept) begin
					cmd_q <= req.data;
					key_q <= key_mask;
					len_q <= len_sat;
					b_q <= BW'(req.data.bucket_index);
					oor_q <= (req.data.command == CMD_CHECK) &&
						(32'(req.data.bucket_index) >= BUCKETS);
					rd_pend_q <= 1'b0;
					hit_q <= 1'b0;
				end
				ST_MOD: if (hash_done) b_q <= BW'(hash_bucket);
				ST_CNT: begin
					rd_pend_q <= !rd_pend_q;
					if (rd_pend_q) begin
						cnt_q <= oor_q ? '0 : c_rdata;
						i_q <= (cmd_q.command == CMD_CHECK) ? (oor_q ? '0 : c_rdata) : '0;
						if (cmd_q.command == CMD_CHECK && (oor_q || c_rdata == '0)) begin
							out_q <= '{kind: KIND_EMPTY, found: 1'b0, entry_key: '0,
								entry_length: '0, last: 1'b1};
							out_v_q <= 1'b1;
						end
					end
				end
				ST_SRCH: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						if (key_match) hit_q <= 1'b1;
						else i_q <= i_q + CW'(1);
					end else if (i_q != cnt_q) begin
						rd_pend_q <= 1'b1;
					end
				end
				ST_DECIDE: begin
					rd_pend_q <= 1'b0;
					if (cmd_q.command == CMD_FIND) begin
						out_q <= '{kind: KIND_FIND, found: hit_q, entry_key: '0,
							entry_length: '0, last: 1'b1};
						out_v_q <= 1'b1;
					end else if (cmd_q.command == CMD_ADD && !hit_q && cnt_q >= CW'(WAYS)) begin
						out_q <= '{kind: KIND_FULL, found: 1'b0, entry_key: '0,
							entry_length: '0, last: 1'b1};
						out_v_q <= 1'b1;
					end
				end
				ST_SHIFT: begin
					// Read slot i+1, then write it into slot i on the next cycle.
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						i_q <= i_q + CW'(1);
					end else if (i_q + CW'(1) < cnt_q) begin
						rd_pend_q <= 1'b1;
					end
				end
				ST_LIST: begin
					if (rd_pend_q) begin
						if (out_free) begin
							out_q <= '{kind: KIND_ENTRY, found: 1'b0, entry_key: s_rdata[63:0],
								entry_length: s_rdata[67:64],
								last: (i_q == CW'(1)) || (cnt_q - i_q + CW'(1) >= CW'(MAX_RESULTS))};
							out_v_q <= 1'b1;
							rd_pend_q <= 1'b0;
							if (cnt_q - i_q + CW'(1) >= CW'(MAX_RESULTS)) i_q <= '0;
							else i_q <= i_q - CW'(1);
						end
					end else if (i_q != '0) begin
						rd_pend_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	`HCT_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !req.ready)
	`HCT_ASSERT_IMPL(a_cnt_bound, clk, arst_n, state_q == ST_SRCH, cnt_q <= CW'(WAYS))
	`HCT_ASSERT_NEXT(a_out_hold, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid)
endmodule

// ----- hdl/hct_hash.sv -----
// Polynomial hash unit: one key byte per cycle, then a bucket reduction.
module hct_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] key,
	input  logic [3:0]  len,
	input  logic [6:0]  buckets,
	output logic        done,
	output logic [11:0] bucket
);
	import hct_pkg::*;
	logic [29:0] h_q;
	logic [3:0]  i_q;
	logic        busy_q, red_q;
	logic [6:0]  nb_q;
	logic [38:0] prod;
	logic [39:0] sum;
	logic [39:0] rem;
	logic [7:0]  byte_v;
	logic [2:0]  bsel;
	logic [29:0] r_q;
	logic [4:0]  rs_q;

	assign bsel = 3'(i_q - 4'd1);
	assign byte_v = key[{bsel, 3'b000} +: 8];
	assign prod = 39'(h_q) * 39'(HASH_MUL);
	assign sum = 40'(prod) + 40'(byte_v);
	// The quotient comes from a reciprocal that never overshoots and is at most
	// one short, so a single subtraction finishes the reduction.
	always_comb begin
		logic [8:0] qe;
		qe = 9'((48'(sum) * 48'd274) >> 38);
		rem = sum - 40'(qe) * 40'(HASH_MOD);
		if (rem >= 40'(HASH_MOD)) rem = rem - 40'(HASH_MOD);
		if (rem >= 40'(HASH_MOD)) rem = rem - 40'(HASH_MOD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			red_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
			rs_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				h_q <= '0;
				i_q <= len;
				nb_q <= (buckets == 7'd0) ? 7'd1 : buckets;
			end else if (busy_q) begin
				if (i_q != 4'd0) begin
					h_q <= 30'(rem);
					i_q <= i_q - 4'd1;
				end else begin
					busy_q <= 1'b0;
					red_q <= 1'b1;
					r_q <= h_q;
					rs_q <= 5'd29;
				end
			end else if (red_q) begin
				// Restoring reduction: subtract nb shifted, one bit per cycle.
				if (36'(r_q) >= (36'(nb_q) << rs_q))
					r_q <= 30'(36'(r_q) - (36'(nb_q) << rs_q));
				if (rs_q == 5'd0) begin
					red_q <= 1'b0;
					done <= 1'b1;
				end else begin
					rs_q <= rs_q - 5'd1;
				end
			end
		end
	end
	assign bucket = 12'(r_q);
endmodule

// ----- sim/hct_tb_if.sv -----
// Shared testbench constants for the hash chain table bench.
package hct_tb_pkg;
	import hct_pkg::*;
	localparam int TB_BUCKETS = 64;
	localparam int TB_WAYS = 8;
	localparam int TB_KEY_BYTES = 8;
	localparam logic [1:0] REG_BUCKETS_IN_USE = 2'd0;
endpackage

// ----- sim/hash_chain_table_checker.sv -----
// Checker that predicts the hash chain table results and compares them with the block.
module hash_chain_table_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  hct_pkg::req_t req_data,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  hct_pkg::rsp_t rsp_data,
	input  logic          cfg_write,
	input  logic [6:0]    cfg_value,
	output int            error_count,
	output int            pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import hct_pkg::*;
	import hct_tb_pkg::*;

	logic [63:0] chain_key[TB_BUCKETS][TB_WAYS];
	logic [3:0]  chain_len[TB_BUCKETS][TB_WAYS];
	int          chain_fill[TB_BUCKETS];
	logic [6:0]  bucket_setting;
	rsp_t        expected_rsp[$];

	function automatic int key_bucket(logic [63:0] key, int len);
		longint unsigned h;
		int n;
		h = 0;
		n = bucket_setting;
		if (n == 0)
			n = 1;
		if (n > TB_BUCKETS)
			n = TB_BUCKETS;
		for (int i = len - 1; i >= 0; i--)
			h = (h * 263 + key[8*i +: 8]) % 64'd1000000007;
		return int'(h % n);
	endfunction

	function automatic rsp_t make_rsp(logic [1:0] kind, logic found, logic [63:0] key,
		logic [3:0] len, logic last);
		rsp_t r;
		r.kind = kind;
		r.found = found;
		r.entry_key = key;
		r.entry_length = len;
		r.last = last;
		return r;
	endfunction

	function automatic void queue_rsp(rsp_t r);
		expected_rsp.insert(expected_rsp.size(), r);
	endfunction

	task automatic apply_command(req_t cmd);
		int len, b, cnt, pos, n;
		logic [63:0] key;
		bit hit;
		if (cmd.command == CMD_CHECK) begin
			b = cmd.bucket_index;
			if (b >= TB_BUCKETS || chain_fill[b] == 0) begin
				queue_rsp(make_rsp(KIND_EMPTY, 1'b0, '0, '0, 1'b1));
				return;
			end
			n = 0;
			for (int i = chain_fill[b] - 1; i >= 0 && n < MAX_RESULTS; i--) begin
				n++;
				queue_rsp(make_rsp(KIND_ENTRY, 1'b0, chain_key[b][i],
					chain_len[b][i], i == 0 || n == MAX_RESULTS));
			end
			return;
		end
		len = cmd.key_length > TB_KEY_BYTES ? TB_KEY_BYTES : cmd.key_length;
		key = '0;
		for (int i = 0; i < len; i++)
			key[8*i +: 8] = cmd.key_bytes[8*i +: 8];
		b = key_bucket(key, len);
		cnt = chain_fill[b];
		hit = 0;
		pos = 0;
		for (int i = 0; i < cnt; i++)
			if (!hit && chain_key[b][i] == key && chain_len[b][i] == len) begin
				hit = 1;
				pos = i;
			end
		case (cmd.command)
			CMD_FIND: begin
				queue_rsp(make_rsp(KIND_FIND, hit, '0, '0, 1'b1));
			end
			CMD_ADD: begin
				if (!hit) begin
					if (cnt >= TB_WAYS) begin
						queue_rsp(make_rsp(KIND_FULL, 1'b0, '0, '0, 1'b1));
					end else begin
						chain_key[b][cnt] = key;
						chain_len[b][cnt] = 4'(len);
						chain_fill[b] = cnt + 1;
					end
				end
			end
			default: begin
				if (hit) begin
					for (int i = pos; i + 1 < cnt; i++) begin
						chain_key[b][i] = chain_key[b][i+1];
						chain_len[b][i] = chain_len[b][i+1];
					end
					chain_fill[b] = cnt - 1;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			error_count <= 0;
			bucket_setting <= 7'd64;
			expected_rsp.delete();
			for (int b = 0; b < TB_BUCKETS; b++)
				chain_fill[b] = 0;
		end else begin
			if (cfg_write)
				bucket_setting <= cfg_value;
			if (req_valid && req_ready)
				apply_command(req_data);
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$error("unexpected transaction kind=%0d", rsp_data.kind);
					error_count <= error_count + 1;
				end else begin
					want = expected_rsp.pop_front();
					if (want != rsp_data) begin
						error_count <= error_count + 1;
						if (want.kind != rsp_data.kind)
							$error("kind: expected %0d got %0d", want.kind, rsp_data.kind);
						if (want.found != rsp_data.found)
							$error("found: expected %0d got %0d", want.found, rsp_data.found);
						if (want.entry_key != rsp_data.entry_key)
							$error("entry_key: expected %h got %h", want.entry_key,
								rsp_data.entry_key);
						if (want.entry_length != rsp_data.entry_length)
							$error("entry_length: expected %0d got %0d", want.entry_length,
								rsp_data.entry_length);
						if (want.last != rsp_data.last)
							$error("last: expected %0d got %0d", want.last, rsp_data.last);
					end
				end
			end
		end
	end

	assign pending_count = expected_rsp.size();
endmodule

// ----- sim/hash_chain_table_tb.sv -----
// Top of the hash chain table testbench: clock, reset, stimulus and verdict.
module hash_chain_table_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hct_pkg::*;
	import hct_tb_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	int          error_count, pending_count, idle_cycles;
	logic [63:0] key_pool[16];
	logic [3:0]  len_pool[16];

	hct_stream_if #(.payload_t(req_t)) req_ch ();
	hct_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	hash_chain_table i_dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	hash_chain_table_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
		.rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
		.cfg_write(psel && penable && pwrite && pready && paddr == REG_BUCKETS_IN_USE),
		.cfg_value(pwdata[6:0]),
		.error_count(error_count), .pending_count(pending_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog: any cycle without a transaction on any channel counts toward the limit.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int gap_length();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
	endfunction

	// Receiver stalls at random; ready is drawn anew on every falling edge.
	always @(negedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else if ($urandom_range(0, 255) < 64)
			rsp_ch.ready <= 1'b1;
		else if ($urandom_range(0, 15) == 0)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= $urandom_range(0, 2) != 0;
	end

	task automatic send(logic [1:0] cmd, logic [63:0] key, logic [3:0] len, logic [5:0] idx);
		req_ch.valid <= 1'b1;
		req_ch.data <= '{command: cmd, key_bytes: key, key_length: len, bucket_index: idx};
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		repeat (gap_length()) @(negedge clk);
	endtask

	task automatic write_buckets(logic [6:0] value);
		while (pending_count != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
		psel <= 1'b1;
		paddr <= REG_BUCKETS_IN_USE;
		pwdata <= {25'd0, value};
		pwrite <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_phase(int count);
		int p;
		logic [63:0] key;
		for (int n = 0; n < count; n++) begin
			p = $urandom_range(0, 15);
			key = {$urandom, $urandom};
			if ($urandom_range(0, 4) != 0)
				key = key_pool[p];
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send(CMD_ADD, key, len_pool[p], 6'($urandom));
				4, 5: send(CMD_DELETE, key, len_pool[p], 6'($urandom));
				6, 7: send(CMD_FIND, key, 4'($urandom_range(0, 15)), 6'($urandom));
				default: send(CMD_CHECK, {$urandom, $urandom}, 4'($urandom), 6'($urandom));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_cycles = 0;
		for (int i = 0; i < 16; i++) begin
			key_pool[i] = {$urandom, $urandom};
			len_pool[i] = 4'($urandom_range(0, 10));
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed part with every bucket folded into one chain to overflow it.
		write_buckets(7'd1);
		for (int i = 0; i < 9; i++)
			send(CMD_ADD, 64'hFFFF_FFFF_FFFF_FF00 | 64'(i), 4'd8, '0);
		send(CMD_ADD, 64'h0, 4'd0, '0);
		send(CMD_ADD, 64'h3, 4'd1, '0);
		send(CMD_CHECK, '0, '0, 6'd0);
		send(CMD_FIND, 64'hFFFF_FFFF_FFFF_FF03, 4'd15, '0);
		send(CMD_FIND, 64'hABCD_0003, 4'd1, '0);
		send(CMD_DELETE, 64'hFFFF_FFFF_FFFF_FF03, 4'd8, '0);
		send(CMD_DELETE, 64'h1234, 4'd2, '0);
		send(CMD_ADD, 64'h0, 4'd0, '0);
		send(CMD_ADD, 64'hFFFF_FFFF_FFFF_FF01, 4'd8, '0);
		send(CMD_CHECK, '0, '0, 6'd0);
		send(CMD_CHECK, '0, '0, 6'd63);
		write_buckets(7'd0);
		send(CMD_FIND, 64'h0, 4'd0, '0);
		write_buckets(7'd127);
		send(CMD_FIND, 64'hFFFF_FFFF_FFFF_FF05, 4'd8, '0);

		random_phase(90);
		write_buckets(7'd3);
		random_phase(90);
		write_buckets(7'd64);
		random_phase(100);
		for (int b = 0; b < 64; b++)
			send(CMD_CHECK, '0, '0, 6'(b));

		while (pending_count != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (error_count == 0 && pending_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
